[rtl/core/gras_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gras_pkg
// Shared types and constants for the glyph ROM address stream block.
// ----------------------------------------------------------------------------
package gras_pkg;

    // Glyph kinds
    localparam logic [1:0] KIND_WIDE   = 2'd0;  // 16x16, 32 bytes
    localparam logic [1:0] KIND_NARROW = 2'd1;  // 8x16, 16 bytes
    localparam logic [1:0] KIND_SMALL  = 2'd2;  // 5x7, 8 bytes

    // Register map (byte addresses)
    localparam logic [1:0] REG_FONT_MODE = 2'd0;

    // Byte classes
    localparam logic [7:0] HANZI_LEAD_LO  = 8'hB0;
    localparam logic [7:0] HANZI_LEAD_HI  = 8'hF7;
    localparam logic [7:0] SYMBOL_LEAD_LO = 8'hA1;
    localparam logic [7:0] SYMBOL_LEAD_HI = 8'hA3;
    localparam logic [7:0] TRAIL_LO       = 8'hA1;
    localparam logic [7:0] PRINT_LO       = 8'h20;
    localparam logic [7:0] PRINT_HI       = 8'h7E;

    // Glyph table geometry
    localparam logic [12:0] GB_ROW_LEN     = 13'd94;
    localparam logic [12:0] HANZI_IDX_BASE = 13'd846;
    localparam logic [23:0] ASCII_WIDE_BASE  = 24'h03CF80;
    localparam logic [23:0] ASCII_SMALL_BASE = 24'h03BFC0;

    // Column advance per glyph kind
    localparam logic [7:0] ADV_WIDE   = 8'd16;
    localparam logic [7:0] ADV_NARROW = 8'd8;
    localparam logic [7:0] ADV_SMALL  = 8'd6;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic [7:0] start_column;
        logic [2:0] start_page;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] held_lead;
        logic       lead_pending;
        logic [7:0] cursor_column;
        logic [2:0] cursor_page;
        logic       string_active;
    } t_state;

    typedef struct packed {
        logic [23:0] rom_address;
        logic [1:0]  glyph_kind;
        logic [7:0]  glyph_column;
        logic [2:0]  glyph_page;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/gras_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gras_decode
// Classifies one text byte against the cursor state, forms the glyph ROM
// address and produces the next cursor state.
// ----------------------------------------------------------------------------
module gras_decode
    import gras_pkg::*;
(
    input  wire t_item   i_item,
    input  wire t_state  i_state,
    input  wire          i_font_mode,
    output t_state       o_state,
    output t_result      o_result,
    output logic         o_emit
);

    logic [7:0]  b;
    logic        b_hanzi_lead;
    logic        b_symbol_lead;
    logic        b_printable;
    logic        held_hanzi;
    logic [7:0]  lead_off;
    logic [7:0]  trail_off;
    logic [7:0]  asc_off;
    logic [12:0] wide_idx;
    logic [23:0] wide_addr;
    logic [23:0] narrow_addr;
    logic [23:0] small_addr;

    // Byte classification
    assign b             = i_item.text_byte;
    assign b_hanzi_lead  = (b >= HANZI_LEAD_LO) && (b <= HANZI_LEAD_HI);
    assign b_symbol_lead = (b >= SYMBOL_LEAD_LO) && (b <= SYMBOL_LEAD_HI);
    assign b_printable   = (b >= PRINT_LO) && (b <= PRINT_HI);

    // Double-byte glyph index: row * 94 + cell, hanzi rows after the symbols
    assign held_hanzi = (i_state.held_lead >= HANZI_LEAD_LO);
    assign lead_off   = held_hanzi ? (i_state.held_lead - HANZI_LEAD_LO)
                                   : (i_state.held_lead - SYMBOL_LEAD_LO);
    assign trail_off  = b - TRAIL_LO;
    assign wide_idx   = 13'(lead_off[6:0]) * GB_ROW_LEN + 13'(trail_off[6:0])
                      + (held_hanzi ? HANZI_IDX_BASE : 13'd0);
    assign wide_addr  = 24'({wide_idx, 5'b0});

    // Single-byte glyphs
    assign asc_off     = b - PRINT_LO;
    assign narrow_addr = 24'({asc_off[6:0], 4'b0}) + ASCII_WIDE_BASE;
    assign small_addr  = 24'({asc_off[6:0], 3'b0}) + ASCII_SMALL_BASE;

    // Sequencing of one byte
    always_comb begin
        t_state     st;
        logic [7:0] adv;
        st     = i_state;
        adv    = 8'd0;
        o_emit = 1'b0;
        o_result.rom_address = 24'd0;
        o_result.glyph_kind  = KIND_WIDE;

        // string start reloads the cursor
        if (i_item.first_byte) begin
            st.cursor_column = i_item.start_column;
            st.cursor_page   = i_item.start_page;
            st.lead_pending  = 1'b0;
            st.string_active = 1'b1;
        end

        o_result.glyph_column = st.cursor_column;
        o_result.glyph_page   = st.cursor_page;

        if (st.string_active) begin
            if (b == 8'd0) begin
                st.lead_pending  = 1'b0;
                st.string_active = 1'b0;
            end else begin
                if (i_font_mode) begin
                    st.lead_pending = 1'b0;
                    if (b_printable) begin
                        o_emit = 1'b1;
                        o_result.rom_address = small_addr;
                        o_result.glyph_kind  = KIND_SMALL;
                        adv = ADV_SMALL;
                    end
                end else if (st.lead_pending && (b >= TRAIL_LO)) begin
                    st.lead_pending = 1'b0;
                    o_emit = 1'b1;
                    o_result.rom_address = wide_addr;
                    o_result.glyph_kind  = KIND_WIDE;
                    adv = ADV_WIDE;
                end else begin
                    // no valid trail: drop any held lead, take byte afresh
                    st.lead_pending = 1'b0;
                    if (b_hanzi_lead || b_symbol_lead) begin
                        st.held_lead    = b;
                        st.lead_pending = 1'b1;
                    end else if (b_printable) begin
                        o_emit = 1'b1;
                        o_result.rom_address = narrow_addr;
                        o_result.glyph_kind  = KIND_NARROW;
                        adv = ADV_NARROW;
                    end
                end

                if (i_item.last_byte) begin
                    st.lead_pending  = 1'b0;
                    st.string_active = 1'b0;
                end
            end
        end

        st.cursor_column = st.cursor_column + adv;
        o_state = st;
    end

endmodule
`default_nettype wire

[rtl/core/glyph_rom_address_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// A byte passes the input register, then the result register, before its glyph
// is valid on the result channel.
// Throughput: one text byte per cycle; a byte that yields a glyph waits in the
// input register only while the result register holds a stalled glyph.
// Reset (synchronous, active low) clears the cursor state, the held lead,
// the font mode and both valid flags.
// ----------------------------------------------------------------------------
// glyph_rom_address_stream
// Turns a GB2312/ASCII byte stream into font ROM glyph addresses with the
// display column and page of each glyph.
// ----------------------------------------------------------------------------
module glyph_rom_address_stream
    import gras_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_text_byte,
    input  wire         i_first_byte,
    input  wire  [7:0]  i_start_column,
    input  wire  [2:0]  i_start_page,
    input  wire         i_last_byte,

    // result channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [23:0] o_rom_address,
    output logic [1:0]  o_glyph_kind,
    output logic [7:0]  o_glyph_column,
    output logic [2:0]  o_glyph_page
);

    logic    r_font_mode;
    logic    r_item_valid;
    t_item   r_item;
    t_state  r_state;
    logic    r_out_valid;
    t_result r_result;

    t_state  n_state;
    t_result dec_result;
    logic    dec_emit;
    logic    out_free;
    logic    advance;
    logic    cfg_write;

    // Register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_FONT_MODE);
    assign prdata    = (paddr == REG_FONT_MODE) ? {31'd0, r_font_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_mode <= 1'b0;
        end else if (cfg_write) begin
            r_font_mode <= pwdata[0];
        end
    end

    // Decode of the registered byte
    gras_decode u_decode (
        .i_item      (r_item),
        .i_state     (r_state),
        .i_font_mode (r_font_mode),
        .o_state     (n_state),
        .o_result    (dec_result),
        .o_emit      (dec_emit)
    );

    // Handshake: a byte without a glyph moves on even if the result is stalled
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_item_valid && (!dec_emit || out_free);
    assign o_ready  = !r_item_valid || advance;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
        end else begin
            if (o_ready) begin
                r_item_valid <= i_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && dec_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.text_byte    <= i_text_byte;
            r_item.first_byte   <= i_first_byte;
            r_item.start_column <= i_start_column;
            r_item.start_page   <= i_start_page;
            r_item.last_byte    <= i_last_byte;
        end
        if (advance && dec_emit) begin
            r_result <= dec_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rom_address  = r_result.rom_address;
    assign o_glyph_kind   = r_result.glyph_kind;
    assign o_glyph_column = r_result.glyph_column;
    assign o_glyph_page   = r_result.glyph_page;

endmodule
`default_nettype wire
